@@ design/aps_pkg.sv @@
// shared types and constants for the adjacent prime search block
package aps_pkg;

    // fixed field widths
    localparam int VAL_W = 16;
    // trial divisors never exceed sqrt(65535) + 1 = 256
    localparam int DIV_W = 9;
    // running square of the divisor, reaches 65536 at most
    localparam int SQ_W  = 17;
    // bit counter of the shared divider
    localparam int CNT_W = $clog2(VAL_W);

    // operation codes
    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_PREV = 1'b1;

    // smallest prime, also the first trial divisor
    localparam logic [VAL_W-1:0] SMALLEST_PRIME = VAL_W'(2);

    typedef struct packed {
        logic             operation;
        logic [VAL_W-1:0] start_value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] prime;
        logic             found;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_TEST,
        S_CHECK,
        S_WAIT,
        S_FINISH
    } t_state;

endpackage

@@ design/aps_if.sv @@
// valid/ready channel interfaces for the adjacent prime search block
interface aps_in_if;
    logic               valid;
    logic               ready;
    aps_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface aps_out_if;
    logic               valid;
    logic               ready;
    aps_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/aps_div.sv @@
// shared restoring divider, one quotient bit per cycle, returns the remainder
module aps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [aps_pkg::VAL_W-1:0]  i_dividend,
    input  logic [aps_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [aps_pkg::DIV_W-1:0]  o_remainder
);

    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [aps_pkg::CNT_W-1:0]  r_count, n_count;
    logic [aps_pkg::VAL_W-1:0]  r_dvd, n_dvd;
    logic [aps_pkg::DIV_W-1:0]  r_dsr, n_dsr;
    logic [aps_pkg::DIV_W-1:0]  r_rem, n_rem;
    logic [aps_pkg::DIV_W:0]    trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_dvd   = r_dvd;
        n_dsr   = r_dsr;
        n_rem   = r_rem;
        trial   = {r_rem, r_dvd[aps_pkg::VAL_W-1]};
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = '0;
            n_dvd   = i_dividend;
            n_dsr   = i_divisor;
            n_rem   = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[aps_pkg::VAL_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = aps_pkg::DIV_W'(trial - {1'b0, r_dsr});
            end else begin
                n_rem = trial[aps_pkg::DIV_W-1:0];
            end
            n_count = r_count + 1'b1;
            if (r_count == aps_pkg::CNT_W'(aps_pkg::VAL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

@@ design/adjacent_prime_search.sv @@
// top level: nearest prime above or below a start value by trial division
//
// usage
//   input channel i_in carries operation and start_value; operation next
//   searches strictly above start_value, operation prev strictly below
//   output channel o_out carries prime and found, one result per item;
//   found low with prime zero when no prime lies in 0 .. limit
//   limit is 2^VALUE_WIDTH - 1, capped at 65535; start_value is masked to
//   VALUE_WIDTH bits before the search
// latency and throughput
//   one item at a time; i_in.ready is high only while the sequencer idles
//   each candidate is tested against trial divisors from 2 up to
//   sqrt(candidate), stopping at the first divisor that leaves no
//   remainder; all trial divisions of all candidates visited run one
//   after another on the single bit-serial divider
// reset
//   synchronous active-low reset returns the sequencer to idle and empties
//   the output register
// stall
//   the result sits in an output register; while the receiver stalls the
//   sequencer may search a new item, whose result waits in finish state
module adjacent_prime_search #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aps_in_if.sink    i_in,
    aps_out_if.source o_out
);

    // search bound, also the mask applied to the start value
    localparam logic [aps_pkg::VAL_W-1:0] LIMIT = (VALUE_WIDTH >= aps_pkg::VAL_W) ?
        {aps_pkg::VAL_W{1'b1}} : aps_pkg::VAL_W'((64'd1 << VALUE_WIDTH) - 64'd1);

    aps_pkg::t_state            r_state, n_state;
    logic                       r_op, n_op;
    logic [aps_pkg::VAL_W-1:0]  r_cand, n_cand;
    logic [aps_pkg::DIV_W-1:0]  r_div, n_div;
    logic [aps_pkg::SQ_W-1:0]   r_sq, n_sq;
    logic                       r_out_valid, n_out_valid;
    aps_pkg::t_out_item         r_out, n_out;
    aps_pkg::t_out_item         r_res, n_res;

    logic                       div_start;
    logic                       div_done;
    logic [aps_pkg::DIV_W-1:0]  div_rem;
    logic                       in_xfer;

    // the one divider: candidate modulo trial divisor
    aps_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_cand),
        .i_divisor   (r_div),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    assign i_in.ready = (r_state == aps_pkg::S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cand      = r_cand;
        n_div       = r_div;
        n_sq        = r_sq;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;

        // output register drains independently of the sequencer
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            aps_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_op    = i_in.payload.operation;
                    n_cand  = i_in.payload.start_value & LIMIT;
                    n_state = aps_pkg::S_STEP;
                end
            end
            // move to the next candidate or give up at the range edge
            aps_pkg::S_STEP: begin
                if (r_op == aps_pkg::OP_NEXT) begin
                    if (r_cand == LIMIT) begin
                        n_res   = '{prime: '0, found: 1'b0};
                        n_state = aps_pkg::S_FINISH;
                    end else begin
                        n_cand  = r_cand + 1'b1;
                        n_state = aps_pkg::S_TEST;
                    end
                end else begin
                    if (r_cand <= aps_pkg::SMALLEST_PRIME) begin
                        n_res   = '{prime: '0, found: 1'b0};
                        n_state = aps_pkg::S_FINISH;
                    end else begin
                        n_cand  = r_cand - 1'b1;
                        n_state = aps_pkg::S_TEST;
                    end
                end
            end
            // zero and one are not prime; otherwise start at divisor two
            aps_pkg::S_TEST: begin
                if (r_cand < aps_pkg::SMALLEST_PRIME) begin
                    n_state = aps_pkg::S_STEP;
                end else begin
                    n_div   = aps_pkg::DIV_W'(aps_pkg::SMALLEST_PRIME);
                    n_sq    = aps_pkg::SQ_W'(4);
                    n_state = aps_pkg::S_CHECK;
                end
            end
            // divisor squared past the candidate means no factor exists
            aps_pkg::S_CHECK: begin
                if (r_sq > {1'b0, r_cand}) begin
                    n_res   = '{prime: r_cand, found: 1'b1};
                    n_state = aps_pkg::S_FINISH;
                end else begin
                    div_start = 1'b1;
                    n_state   = aps_pkg::S_WAIT;
                end
            end
            aps_pkg::S_WAIT: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_state = aps_pkg::S_STEP;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_sq    = r_sq + aps_pkg::SQ_W'({r_div, 1'b1});
                        n_div   = r_div + 1'b1;
                        n_state = aps_pkg::S_CHECK;
                    end
                end
            end
            // load the result once the output register is free
            aps_pkg::S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = aps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aps_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_cand <= n_cand;
        r_div  <= n_div;
        r_sq   <= n_sq;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

@@ design/aps_chk.sv @@
// port-level checker for the adjacent prime search block, with its bind
module aps_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  aps_pkg::t_out_item i_out_payload
);

    // a held result keeps its value while the receiver stalls
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_payload))
        else $error("result changed while stalled");

    // block is busy right after taking an item
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after an input transfer");

    // no prime found reports a zero prime
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_payload.found |-> i_out_payload.prime == '0)
        else $error("nonzero prime without found");

    // a found prime is at least two
    a_hit_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.found |->
            i_out_payload.prime >= aps_pkg::SMALLEST_PRIME)
        else $error("found prime below two");

endmodule

bind adjacent_prime_search aps_chk u_aps_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

@@ sim/adjacent_prime_search_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the adjacent prime search block
module adjacent_prime_search_test;

    localparam int TB_VALUE_WIDTH = 16;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 7;
    // a prime candidate near the top is tried against about 254 divisors,
    // a wide prime gap adds a few dozen cheap composites; taken well over
    localparam int STALL_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 64;

    logic i_clk;
    logic i_rst_n;

    aps_in_if  in_bus();
    aps_out_if out_bus();

    adjacent_prime_search #(
        .VALUE_WIDTH(TB_VALUE_WIDTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // idle percentages of the sender and the receiver
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    aps_pkg::t_out_item expected_primes[$];
    int unsigned        error_count;
    int unsigned        stall_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // largest value the search may visit
    function automatic int unsigned search_limit();
        if (TB_VALUE_WIDTH >= 16) begin
            return 32'hFFFF;
        end
        return (32'd1 << TB_VALUE_WIDTH) - 32'd1;
    endfunction

    function automatic bit is_prime_value(input int unsigned n);
        int unsigned d;
        if (n < 2) begin
            return 1'b0;
        end
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // nearest prime strictly above or below the start value
    function automatic aps_pkg::t_out_item adjacent_prime(input aps_pkg::t_in_item item);
        aps_pkg::t_out_item res;
        int unsigned        lim;
        int unsigned        start;
        int unsigned        c;
        lim         = search_limit();
        start       = int'(item.start_value) & lim;
        res.prime   = '0;
        res.found   = 1'b0;
        if (item.operation == aps_pkg::OP_NEXT) begin
            for (c = start + 1; c <= lim; c++) begin
                if (is_prime_value(c)) begin
                    res.prime = aps_pkg::VAL_W'(c);
                    res.found = 1'b1;
                    break;
                end
            end
        end else begin
            c = start;
            while (c > 2) begin
                c--;
                if (is_prime_value(c)) begin
                    res.prime = aps_pkg::VAL_W'(c);
                    res.found = 1'b1;
                    break;
                end
            end
        end
        return res;
    endfunction

    // drive one search request and wait for its transfer
    task automatic send_search(input logic op, input logic [aps_pkg::VAL_W-1:0] start);
        aps_pkg::t_in_item item;
        item.operation   = op;
        item.start_value = start;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.payload <= item;
        @(posedge i_clk);
        while (!in_bus.ready) begin
            @(posedge i_clk);
        end
    endtask

    // receiver back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // predict on every input transfer, check on every output transfer;
    // one process so that order within a step does not matter
    always @(posedge i_clk) begin : result_check
        aps_pkg::t_out_item want;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            expected_primes.push_back(adjacent_prime(in_bus.payload));
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_primes.size() == 0) begin
                $error("unexpected result: prime %0d found %0b",
                       out_bus.payload.prime, out_bus.payload.found);
                error_count++;
            end else begin
                want = expected_primes.pop_front();
                if (out_bus.payload.prime !== want.prime) begin
                    $error("prime: expected %0d, actual %0d",
                           want.prime, out_bus.payload.prime);
                    error_count++;
                end
                if (out_bus.payload.found !== want.found) begin
                    $error("found: expected %0b, actual %0b",
                           want.found, out_bus.payload.found);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // smallest primes and the top of the range, upward
    task automatic test_upward_edges();
        send_search(aps_pkg::OP_NEXT, 16'd0);
        send_search(aps_pkg::OP_NEXT, 16'd1);
        send_search(aps_pkg::OP_NEXT, 16'd2);
        send_search(aps_pkg::OP_NEXT, 16'd3);
        send_search(aps_pkg::OP_NEXT, 16'd65519);
        send_search(aps_pkg::OP_NEXT, 16'd65520);
        // widest gap below 65536
        send_search(aps_pkg::OP_NEXT, 16'd31397);
    endtask

    // smallest primes and the top of the range, downward
    task automatic test_downward_edges();
        send_search(aps_pkg::OP_PREV, 16'd3);
        send_search(aps_pkg::OP_PREV, 16'd4);
        send_search(aps_pkg::OP_PREV, 16'd5);
        send_search(aps_pkg::OP_PREV, 16'd65535);
        send_search(aps_pkg::OP_PREV, 16'd65521);
        send_search(aps_pkg::OP_PREV, 16'd31469);
    endtask

    // no prime in range: past the top going up, at or below two going down
    task automatic test_no_prime_in_range();
        send_search(aps_pkg::OP_NEXT, 16'd65521);
        send_search(aps_pkg::OP_NEXT, 16'd65534);
        send_search(aps_pkg::OP_NEXT, 16'd65535);
        send_search(aps_pkg::OP_PREV, 16'd0);
        send_search(aps_pkg::OP_PREV, 16'd1);
        send_search(aps_pkg::OP_PREV, 16'd2);
    endtask

    // alternating and single-bit start values
    task automatic test_bit_patterns();
        send_search(aps_pkg::OP_NEXT, 16'hAAAA);
        send_search(aps_pkg::OP_PREV, 16'h5555);
        send_search(aps_pkg::OP_NEXT, 16'h8000);
        send_search(aps_pkg::OP_PREV, 16'h7FFF);
    endtask

    // mostly small starts to keep searches short, some full-range, some edges
    task automatic test_random_searches(input int unsigned count);
        int unsigned               n;
        int unsigned               pick;
        logic [aps_pkg::VAL_W-1:0] start;
        logic                      op;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op   = 1'($urandom_range(1));
            if (pick < 60) begin
                start = aps_pkg::VAL_W'($urandom_range(1023));
            end else if (pick < 85) begin
                start = aps_pkg::VAL_W'($urandom);
            end else if ($urandom_range(1) == 1) begin
                start = aps_pkg::VAL_W'($urandom_range(65535, 65400));
            end else begin
                start = aps_pkg::VAL_W'($urandom_range(8));
            end
            send_search(op, start);
        end
    endtask

    initial begin
        error_count    = 0;
        tx_idle_pct    = 11;
        rx_idle_pct    = 54;
        in_bus.valid   = 1'b0;
        in_bus.payload = '0;
        out_bus.ready  = 1'b0;
        i_rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        test_upward_edges();
        test_downward_edges();
        test_no_prime_in_range();
        test_bit_patterns();
        test_random_searches(39);

        // roles swapped
        tx_idle_pct = 54;
        rx_idle_pct = 11;
        test_random_searches(39);

        // back to back
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_searches(39);

        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (expected_primes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_primes.size() != 0) begin
            $error("%0d results never arrived", expected_primes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/aps_pkg.sv
design/aps_if.sv
design/aps_div.sv
design/adjacent_prime_search.sv
design/aps_chk.sv
sim/adjacent_prime_search_test.sv
